// ===== sv/cdc_pkg.sv =====
package cdc_pkg;

  // default sizes of the year counter and the day counters
  localparam int YEAR_BITS_DEF  = 12;
  localparam int COUNT_BITS_DEF = 24;

  // fixed field widths
  localparam int MONTH_W   = 4;
  localparam int DOM_W     = 5;
  localparam int WDAY_W    = 3;
  localparam int DOY_W     = 9;
  localparam int M_WDAY_W  = 4;
  localparam int M_MONTH_W = 5;
  localparam int M_DAY_W   = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WEEKDAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_YEAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MONTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_OFFSET    = 3'd4;

  // month and weekday codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  localparam logic [WDAY_W-1:0] WDAY_MONDAY = 3'd0;
  localparam logic [WDAY_W-1:0] WDAY_FRIDAY = 3'd4;
  localparam logic [WDAY_W-1:0] WDAY_SUNDAY = 3'd6;

  localparam logic [DOY_W-1:0] DAYS_LEAP_YEAR = 9'd366;
  localparam logic [DOY_W-1:0] DAYS_YEAR      = 9'd365;

  // date of the day just entered, apart from the year
  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
    logic [DOY_W-1:0]   day_in_year;
    logic               leap;
  } cdc_date_t;

  function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DOM_W-1:0] len;
    case (m) inside
      MONTH_FEB:                               len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default:                                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/cdc_calendar.sv =====
module cdc_calendar
  import cdc_pkg::*;
#(
  parameter int YEAR_BITS = YEAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 restart,
  output logic [YEAR_BITS-1:0] year_now,
  output cdc_date_t            date_now
);

  logic [YEAR_BITS-1:0] year_r, year_c, year_nxt;
  logic [DOY_W-1:0]     doy_r, doy_c, doy_a, doy_nxt;
  logic [MONTH_W-1:0]   month_r, month_c, month_nxt;
  logic [DOM_W-1:0]     dom_r, dom_c, dom_a, dom_nxt;
  logic [WDAY_W-1:0]    wday_r, wday_c, wday_nxt;
  logic                 leap_c, leap_a, year_roll, month_roll;
  logic [DOY_W-1:0]     year_len;
  logic [DOM_W-1:0]     mlen;

  always_comb begin
    // restart puts the calendar back to its start before the tick
    year_c  = restart ? '0 : year_r;
    doy_c   = restart ? '0 : doy_r;
    month_c = restart ? MONTH_JAN : month_r;
    dom_c   = restart ? '0 : dom_r;
    wday_c  = restart ? WDAY_FRIDAY : wday_r;

    leap_c    = (year_c[1:0] == 2'd0);
    year_len  = leap_c ? DAYS_LEAP_YEAR : DAYS_YEAR;
    year_roll = (doy_c >= year_len);
    year_nxt  = year_roll ? year_c + 1'b1 : year_c;
    doy_a     = year_roll ? '0 : doy_c;
    leap_a    = (year_nxt[1:0] == 2'd0);

    mlen       = month_len(month_c, leap_a);
    month_roll = (dom_c >= mlen);
    if (month_roll) begin
      month_nxt = (month_c >= MONTH_DEC) ? MONTH_JAN : month_c + 1'b1;
    end else begin
      month_nxt = month_c;
    end
    dom_a = month_roll ? '0 : dom_c;

    doy_nxt  = doy_a + 1'b1;
    dom_nxt  = dom_a + 1'b1;
    wday_nxt = (wday_c >= WDAY_SUNDAY) ? WDAY_MONDAY : wday_c + 1'b1;
  end

  assign year_now             = year_nxt;
  assign date_now.month       = month_nxt;
  assign date_now.day         = dom_nxt;
  assign date_now.weekday     = wday_c;
  assign date_now.day_in_year = doy_nxt;
  assign date_now.leap        = leap_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= '0;
      doy_r   <= '0;
      month_r <= MONTH_JAN;
      dom_r   <= '0;
      wday_r  <= WDAY_FRIDAY;
    end else if (step) begin
      year_r  <= year_nxt;
      doy_r   <= doy_nxt;
      month_r <= month_nxt;
      dom_r   <= dom_nxt;
      wday_r  <= wday_nxt;
    end
  end

endmodule

// ===== sv/cdc_match.sv =====
module cdc_match
  import cdc_pkg::*;
#(
  parameter int YEAR_BITS  = YEAR_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  restart,
  input  logic [YEAR_BITS-1:0]  year_now,
  input  cdc_date_t             date_now,
  input  logic [M_WDAY_W-1:0]   match_weekday,
  input  logic [YEAR_BITS:0]    match_year,
  input  logic [M_MONTH_W-1:0]  match_month,
  input  logic [M_DAY_W-1:0]    match_day,
  input  logic [COUNT_BITS:0]   day_offset,
  output logic                  date_match,
  output logic                  offset_hit,
  output logic [COUNT_BITS-1:0] total_days
);

  logic [COUNT_BITS-1:0] elapsed_r, elapsed_c, elapsed_nxt;
  logic [COUNT_BITS-1:0] since_r, since_c, since_nxt;
  logic                  matched_r, matched_c, matched_nxt;
  logic                  wday_ok, year_ok, month_ok, day_ok;

  always_comb begin
    elapsed_c = restart ? '0 : elapsed_r;
    since_c   = restart ? '0 : since_r;
    matched_c = restart ? 1'b0 : matched_r;

    // both counters saturate at all ones
    elapsed_nxt = (elapsed_c != '1) ? elapsed_c + 1'b1 : elapsed_c;
    since_nxt   = (matched_c && since_c != '1) ? since_c + 1'b1 : since_c;

    // all ones is the wildcard, any other negative value never matches
    wday_ok  = (match_weekday == '1) ||
               (!match_weekday[M_WDAY_W-1] &&
                match_weekday[M_WDAY_W-2:0] == date_now.weekday);
    year_ok  = (match_year == '1) ||
               (!match_year[YEAR_BITS] && match_year[YEAR_BITS-1:0] == year_now);
    month_ok = (match_month == '1) ||
               (!match_month[M_MONTH_W-1] &&
                match_month[M_MONTH_W-2:0] == date_now.month);
    day_ok   = (match_day == '1) ||
               (!match_day[M_DAY_W-1] && match_day[M_DAY_W-2:0] == date_now.day);

    offset_hit  = !day_offset[COUNT_BITS] && (day_offset[COUNT_BITS-1:0] == since_nxt);
    date_match  = (wday_ok && year_ok && month_ok && day_ok) || offset_hit;
    matched_nxt = matched_c || date_match;
  end

  assign total_days = elapsed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      since_r   <= '0;
      matched_r <= 1'b0;
    end else if (step) begin
      elapsed_r <= elapsed_nxt;
      since_r   <= since_nxt;
      matched_r <= matched_nxt;
    end
  end

endmodule

// ===== sv/calendar_day_counter_with_match.sv =====
// Julian calendar day counter with wildcard date match. Every transfer on the
// in_ stream is one day tick and yields exactly one transfer on the out_
// stream carrying the date just entered (year, month, day, weekday, ordinal
// day, leap flag), the saturating day count and two flags: date_match when
// weekday, year, month and day all agree with the match registers (all ones
// in a register means any) or when offset_hit is set, and offset_hit when the
// days since the first match equal day_offset. The calendar starts at year 0,
// January 1, a Friday, every fourth year is leap, and the year wraps. Setting
// restart in a tick returns the calendar and counters to that start before
// the day is counted; the match registers keep their values. One item is
// taken every clock cycle unless the output stalls: the date counters are
// updated and the result register loaded in the same cycle, and input is
// stalled only while a result sits untaken in the output register. Match
// registers may only be written while no tick is outstanding; writes are
// always taken (cfg_ready is tied high) and indexes beyond the register
// list are ignored.
module calendar_day_counter_with_match
  import cdc_pkg::*;
#(
  parameter int YEAR_BITS  = YEAR_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int CFG_W     = COUNT_BITS + 1,
  localparam int RES_W     = 2 + YEAR_BITS + MONTH_W + DOM_W + WDAY_W + DOY_W + 1
                             + COUNT_BITS,
  localparam int OUT_W     = ((RES_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // day tick stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // restart
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // date_match, offset_hit, year_now, month_now,
                                           // day_now, weekday_now, day_in_year,
                                           // leap_year, total_days, zero pad
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // match registers reset to the wildcard, the day offset to all ones, which never hits
  logic [M_WDAY_W-1:0]   match_weekday_r;
  logic [YEAR_BITS:0]    match_year_r;
  logic [M_MONTH_W-1:0]  match_month_r;
  logic [M_DAY_W-1:0]    match_day_r;
  logic [COUNT_BITS:0]   day_offset_r;

  logic                  step;
  logic                  restart;
  logic [YEAR_BITS-1:0]  year_now;
  cdc_date_t             date_now;
  logic                  date_match, offset_hit;
  logic [COUNT_BITS-1:0] total_days;
  logic                  out_valid_r;
  logic [RES_W-1:0]      result_r, result_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_weekday_r <= '1;
      match_year_r    <= '1;
      match_month_r   <= '1;
      match_day_r     <= '1;
      day_offset_r    <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MATCH_WEEKDAY: match_weekday_r <= cfg_data[M_WDAY_W-1:0];
        CFG_MATCH_YEAR:    match_year_r    <= cfg_data[YEAR_BITS:0];
        CFG_MATCH_MONTH:   match_month_r   <= cfg_data[M_MONTH_W-1:0];
        CFG_MATCH_DAY:     match_day_r     <= cfg_data[M_DAY_W-1:0];
        CFG_DAY_OFFSET:    day_offset_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register frees as soon as its content is taken
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;
  assign restart   = in_tdata[0];

  cdc_calendar #(
    .YEAR_BITS (YEAR_BITS)
  ) u_calendar (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .restart  (restart),
    .year_now (year_now),
    .date_now (date_now)
  );

  cdc_match #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_match (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .restart       (restart),
    .year_now      (year_now),
    .date_now      (date_now),
    .match_weekday (match_weekday_r),
    .match_year    (match_year_r),
    .match_month   (match_month_r),
    .match_day     (match_day_r),
    .day_offset    (day_offset_r),
    .date_match    (date_match),
    .offset_hit    (offset_hit),
    .total_days    (total_days)
  );

  // fields packed from the lowest bit up
  assign result_nxt = {total_days, date_now.leap, date_now.day_in_year,
                       date_now.weekday, date_now.day, date_now.month,
                       year_now, offset_hit, date_match};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-RES_W){1'b0}}, result_r};

endmodule
